// File: design/mbc1_bank_controller_defines.svh
// ----------------------------------------------------------------------------
// mbc1_bank_controller_defines.svh
// Assertion macros shared by the bank controller RTL.
// ----------------------------------------------------------------------------
`ifndef MBC1_BANK_CONTROLLER_DEFINES_SVH
`define MBC1_BANK_CONTROLLER_DEFINES_SVH

`ifndef SYNTH

// whenever ante holds at an edge, cons must hold at the same edge
`define MBC1_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbc1 assertion failed");

// ante at one edge requires cons at the next edge
`define MBC1_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbc1 assertion failed");

// expr must never be true outside reset
`define MBC1_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("mbc1 assertion failed");

`else

`define MBC1_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MBC1_ASSERT_NEXT(label, clk, rst, ante, cons)
`define MBC1_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// File: design/mbc1_pkg.sv
// ----------------------------------------------------------------------------
// mbc1_pkg
// Types, codes and constants of the MBC1 bank controller.
// ----------------------------------------------------------------------------
package mbc1_pkg;

  // default store geometry
  localparam int ROM_BANKS_DEF = 128;
  localparam int RAM_BANKS_DEF = 4;

  // byte offset widths within one bank
  localparam int ROM_OFS_W = 14;
  localparam int RAM_OFS_W = 13;

  // bank register layout
  localparam int BANK_W     = 7;
  localparam int BANK_LO_W  = 5;
  localparam int BANK_HI_W  = 2;

  localparam logic [BANK_W-1:0]    BANK_RESET  = 7'd1;
  localparam logic [BANK_LO_W-1:0] BANK_LO_ONE = 5'd1;
  localparam logic [3:0]           RAM_EN_KEY  = 4'hA;
  localparam logic [7:0]           MODE_ROM    = 8'd0;
  localparam logic [7:0]           MODE_RAM    = 8'd1;

  // bus address regions, decoded on address[15:13]
  localparam logic [2:0] REG_RAM_EN  = 3'b000;
  localparam logic [2:0] REG_BANK_LO = 3'b001;
  localparam logic [2:0] REG_BANK_HI = 3'b010;
  localparam logic [2:0] REG_MODE    = 3'b011;
  localparam logic [2:0] WIN_RAM     = 3'b101;

  // address[15:14] windows
  localparam logic [1:0] WIN_ROM0 = 2'b00;
  localparam logic [1:0] WIN_ROMX = 2'b01;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_LOAD_ROM = 2'd2,
    OP_LOAD_RAM = 2'd3
  } op_t;

  // where the read byte of a result comes from
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_ROM  = 2'd1,
    SRC_RAM  = 2'd2
  } src_t;

  typedef struct packed {
    logic rom_we;
    logic rom_re;
    logic ram_we;
    logic ram_re;
  } mem_req_t;

  typedef struct packed {
    src_t src;
    logic bad;
  } res_info_t;

endpackage

// File: design/mbc1_ctrl.sv
// ----------------------------------------------------------------------------
// mbc1_ctrl
// Bank registers and address decode; issues at most one store access per transfer.
// ----------------------------------------------------------------------------
`include "mbc1_bank_controller_defines.svh"

module mbc1_ctrl
  import mbc1_pkg::*;
#(
  parameter int ROM_BANKS = ROM_BANKS_DEF,
  parameter int RAM_BANKS = RAM_BANKS_DEF,
  localparam int ROM_AW = $clog2(ROM_BANKS * (1 << ROM_OFS_W)),
  localparam int RAM_AW = $clog2(RAM_BANKS * (1 << RAM_OFS_W))
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        operation,
  input  logic [15:0]       address,
  input  logic [7:0]        data,
  input  logic [20:0]       image_offset,
  output mem_req_t          req,
  output logic [ROM_AW-1:0] rom_addr,
  output logic [RAM_AW-1:0] ram_addr,
  output res_info_t         info
);

  logic [BANK_W-1:0] bank_select;
  logic [BANK_W-1:0] bank_select_next;
  logic              ram_banking_mode;
  logic              ram_banking_mode_next;
  logic              ram_enabled;
  logic              ram_enabled_next;

  // bank wrap tables, built at elaboration
  logic [BANK_W-1:0]    rom_wrap [1 << BANK_W];
  logic [BANK_HI_W-1:0] ram_wrap [256];

  for (genvar g = 0; g < (1 << BANK_W); g++) begin : g_rom_wrap
    assign rom_wrap[g] = BANK_W'(g % ROM_BANKS);
  end
  for (genvar g = 0; g < 256; g++) begin : g_ram_wrap
    assign ram_wrap[g] = BANK_HI_W'(g % RAM_BANKS);
  end

  op_t                  op;
  logic [BANK_W-1:0]    rom_page;
  logic [BANK_HI_W-1:0] ram_page;
  logic [BANK_LO_W-1:0] lo_bits;
  logic                 in_ram_win;

  assign op         = op_t'(operation);
  assign rom_page   = rom_wrap[ram_banking_mode ? {2'b00, bank_select[BANK_LO_W-1:0]}
                                                : bank_select];
  assign ram_page   = ram_wrap[ram_banking_mode ? {6'd0, bank_select[BANK_W-1:BANK_LO_W]}
                                                : 8'd0];
  assign lo_bits    = data[BANK_LO_W-1:0];
  assign in_ram_win = (address[15:13] == WIN_RAM);

  always_comb begin
    bank_select_next      = bank_select;
    ram_banking_mode_next = ram_banking_mode;
    ram_enabled_next      = ram_enabled;
    req                   = '0;
    info.src              = SRC_ZERO;
    info.bad              = 1'b0;
    rom_addr              = ROM_AW'({rom_page, address[ROM_OFS_W-1:0]});
    ram_addr              = RAM_AW'({ram_page, address[RAM_OFS_W-1:0]});
    case (op)
      OP_READ: begin
        if (address[15:14] == WIN_ROM0) begin
          rom_addr   = ROM_AW'(address[ROM_OFS_W-1:0]);
          req.rom_re = accept;
          info.src   = SRC_ROM;
        end else if (address[15:14] == WIN_ROMX) begin
          req.rom_re = accept;
          info.src   = SRC_ROM;
        end else if (in_ram_win && ram_enabled) begin
          req.ram_re = accept;
          info.src   = SRC_RAM;
        end
      end
      OP_WRITE: begin
        if (in_ram_win) begin
          req.ram_we = accept && ram_enabled;
        end else begin
          case (address[15:13])
            REG_RAM_EN:  ram_enabled_next = (data[3:0] == RAM_EN_KEY);
            REG_BANK_LO: bank_select_next[BANK_LO_W-1:0] =
                           (lo_bits == '0) ? BANK_LO_ONE : lo_bits;
            REG_BANK_HI: bank_select_next[BANK_W-1:BANK_LO_W] = data[BANK_HI_W-1:0];
            REG_MODE: begin
              if (data == MODE_ROM) begin
                ram_banking_mode_next = 1'b0;
              end else if (data == MODE_RAM) begin
                ram_banking_mode_next = 1'b1;
              end else begin
                info.bad = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      OP_LOAD_ROM: begin
        rom_addr   = ROM_AW'({rom_wrap[image_offset[20:ROM_OFS_W]],
                              image_offset[ROM_OFS_W-1:0]});
        req.rom_we = accept;
      end
      OP_LOAD_RAM: begin
        ram_addr   = RAM_AW'({ram_wrap[image_offset[20:RAM_OFS_W]],
                              image_offset[RAM_OFS_W-1:0]});
        req.ram_we = accept;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select      <= BANK_RESET;
      ram_banking_mode <= 1'b0;
      ram_enabled      <= 1'b0;
    end else if (accept) begin
      bank_select      <= bank_select_next;
      ram_banking_mode <= ram_banking_mode_next;
      ram_enabled      <= ram_enabled_next;
    end
  end

  `MBC1_ASSERT_NEVER(a_bank_lo_nonzero, clk, rst, bank_select[BANK_LO_W-1:0] == '0)
  `MBC1_ASSERT_NEVER(a_one_access, clk, rst,
                     !$onehot0({req.rom_we, req.rom_re, req.ram_we, req.ram_re}))
  `MBC1_ASSERT_NEXT(a_bad_mode_holds, clk, rst, accept && info.bad,
                    $stable(ram_banking_mode))
  `MBC1_ASSERT_IMPLIES(a_ram_gated, clk, rst, req.ram_re, ram_enabled)

endmodule

// File: design/mbc1_store.sv
// ----------------------------------------------------------------------------
// mbc1_store
// ROM and RAM stores: one synchronous port each, registered read data.
// ----------------------------------------------------------------------------
module mbc1_store
  import mbc1_pkg::*;
#(
  parameter int ROM_BANKS = ROM_BANKS_DEF,
  parameter int RAM_BANKS = RAM_BANKS_DEF,
  localparam int ROM_DEPTH = ROM_BANKS * (1 << ROM_OFS_W),
  localparam int RAM_DEPTH = RAM_BANKS * (1 << RAM_OFS_W),
  localparam int ROM_AW = $clog2(ROM_DEPTH),
  localparam int RAM_AW = $clog2(RAM_DEPTH)
) (
  input  logic              clk,
  input  mem_req_t          req,
  input  logic [ROM_AW-1:0] rom_addr,
  input  logic [RAM_AW-1:0] ram_addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rom_q,
  output logic [7:0]        ram_q
);

  logic [7:0] rom_mem [ROM_DEPTH];
  logic [7:0] ram_mem [RAM_DEPTH];

  // an item either reads or writes, so no read-during-write case arises;
  // a read in the next cycle already sees the written byte
  always_ff @(posedge clk) begin
    if (req.rom_we) begin
      rom_mem[rom_addr] <= wdata;
    end
    if (req.rom_re) begin
      rom_q <= rom_mem[rom_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.ram_we) begin
      ram_mem[ram_addr] <= wdata;
    end
    if (req.ram_re) begin
      ram_q <= ram_mem[ram_addr];
    end
  end

endmodule

// File: design/mbc1_out.sv
// ----------------------------------------------------------------------------
// mbc1_out
// Read-return stage and result register with stall handling.
// ----------------------------------------------------------------------------
`include "mbc1_bank_controller_defines.svh"

module mbc1_out
  import mbc1_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  res_info_t  info,
  input  logic [7:0] rom_q,
  input  logic [7:0] ram_q,
  output logic       in_stall,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] read_data,
  output logic       bad_mode_write
);

  logic       s1_valid;
  res_info_t  s1_info;
  logic       load_out;
  logic [7:0] s1_byte;

  // hold input only when both stages are occupied and the output is stalled
  assign in_stall = s1_valid && result_valid && result_stall;
  assign load_out = s1_valid && (!result_valid || !result_stall);

  always_comb begin
    case (s1_info.src)
      SRC_ROM: s1_byte = rom_q;
      SRC_RAM: s1_byte = ram_q;
      default: s1_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (load_out) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      read_data      <= s1_byte;
      bad_mode_write <= s1_info.bad;
    end
  end

  `MBC1_ASSERT_IMPLIES(a_stall_only_full, clk, rst, in_stall, s1_valid && result_valid)
  `MBC1_ASSERT_NEXT(a_s1_drains, clk, rst, s1_valid && !result_stall, result_valid)
  `MBC1_ASSERT_IMPLIES(a_bad_no_data, clk, rst, result_valid && bad_mode_write,
                       read_data == 8'd0)

endmodule

// File: design/mbc1_bank_controller.sv
// ----------------------------------------------------------------------------
// mbc1_bank_controller
// MBC1 cartridge bank controller: bus reads and writes plus image loads
// into the ROM and RAM stores.
// ----------------------------------------------------------------------------
//   channel  handshake                   payload
//   item     item_valid / item_stall     operation, address, data, image_offset
//   result   result_valid / result_stall read_data, bad_mode_write
//
// One transfer per cycle in and out while result_stall is low; a result passes
// through the stores' registered read and the read-return stage into the result register.
// Bank registers update at the item transfer, so the next item sees them.
// Reset clears bank_select to 1, mode and RAM enable to 0; store contents
// are unknown until loaded. A stalled result holds one more item in the
// read-return stage before item_stall rises.
// ----------------------------------------------------------------------------
module mbc1_bank_controller
  import mbc1_pkg::*;
#(
  parameter int ROM_BANKS = ROM_BANKS_DEF,
  parameter int RAM_BANKS = RAM_BANKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  input  logic [20:0] image_offset,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  read_data,
  output logic        bad_mode_write
);

  localparam int ROM_AW = $clog2(ROM_BANKS * (1 << ROM_OFS_W));
  localparam int RAM_AW = $clog2(RAM_BANKS * (1 << RAM_OFS_W));

  logic              accept;
  mem_req_t          req;
  logic [ROM_AW-1:0] rom_addr;
  logic [RAM_AW-1:0] ram_addr;
  res_info_t         info;
  logic [7:0]        rom_q;
  logic [7:0]        ram_q;

  assign accept = item_valid && !item_stall;

  mbc1_ctrl #(
    .ROM_BANKS (ROM_BANKS),
    .RAM_BANKS (RAM_BANKS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .operation    (operation),
    .address      (address),
    .data         (data),
    .image_offset (image_offset),
    .req          (req),
    .rom_addr     (rom_addr),
    .ram_addr     (ram_addr),
    .info         (info)
  );

  mbc1_store #(
    .ROM_BANKS (ROM_BANKS),
    .RAM_BANKS (RAM_BANKS)
  ) u_store (
    .clk      (clk),
    .req      (req),
    .rom_addr (rom_addr),
    .ram_addr (ram_addr),
    .wdata    (data),
    .rom_q    (rom_q),
    .ram_q    (ram_q)
  );

  mbc1_out u_out (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .info           (info),
    .rom_q          (rom_q),
    .ram_q          (ram_q),
    .in_stall       (item_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .read_data      (read_data),
    .bad_mode_write (bad_mode_write)
  );

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bank controller testbench. It sends bus reads and writes and ROM/RAM image
// loads, predicts each read byte and mode-write flag from a cartridge model
// kept alongside, and compares every result in order. Reads only ever target
// store bytes that were loaded or written first.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbc1_pkg::*;

  localparam int unsigned ROM_BANK_SPAN = 1 << ROM_OFS_W;
  localparam int unsigned RAM_BANK_SPAN = 1 << RAM_OFS_W;
  localparam int unsigned ROM_BYTES     = ROM_BANKS_DEF * ROM_BANK_SPAN;
  localparam int unsigned RAM_BYTES     = RAM_BANKS_DEF * RAM_BANK_SPAN;

  typedef struct packed {
    logic [7:0] rd;
    logic       bad;
  } bus_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  operation = OP_READ;
  logic [15:0] address = '0;
  logic [7:0]  data = '0;
  logic [20:0] image_offset = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  read_data;
  logic        bad_mode_write;

  // cartridge model state
  logic [7:0]         rom_img [int unsigned];
  logic [7:0]         ram_img [int unsigned];
  logic [20:0]        rom_keys [$];
  logic [14:0]        ram_keys [$];
  logic [BANK_W-1:0]  bank_sel = BANK_RESET;
  bit                 ram_mode = 1'b0;
  bit                 ram_on = 1'b0;

  bus_reply_t bus_replies [$];
  bus_reply_t oldest_reply;
  int         gap_pct = 31;
  int         stall_pct = 69;
  int         items_sent = 0;
  int         errors = 0;

  mbc1_bank_controller DUT (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .address        (address),
    .data           (data),
    .image_offset   (image_offset),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .read_data      (read_data),
    .bad_mode_write (bad_mode_write)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic int unsigned rom_index(logic [15:0] a);
    int unsigned bank;
    if (a[15:14] == WIN_ROM0) return 32'(a[ROM_OFS_W-1:0]);
    bank = ram_mode ? 32'(bank_sel[BANK_LO_W-1:0]) : 32'(bank_sel);
    return ((bank % ROM_BANKS_DEF) * ROM_BANK_SPAN + 32'(a[ROM_OFS_W-1:0])) % ROM_BYTES;
  endfunction

  function automatic int unsigned ram_index(logic [15:0] a);
    int unsigned bank;
    bank = ram_mode ? 32'(bank_sel[BANK_W-1:BANK_LO_W]) : 0;
    return ((bank % RAM_BANKS_DEF) * RAM_BANK_SPAN + 32'(a[RAM_OFS_W-1:0])) % RAM_BYTES;
  endfunction

  function automatic void put_rom(int unsigned idx, logic [7:0] d);
    if (!rom_img.exists(idx)) rom_keys.push_back(21'(idx));
    rom_img[idx] = d;
  endfunction

  function automatic void put_ram(int unsigned idx, logic [7:0] d);
    if (!ram_img.exists(idx)) ram_keys.push_back(15'(idx));
    ram_img[idx] = d;
  endfunction

  // a read is safe unless it would land on a store byte never written
  function automatic bit reachable(logic [15:0] a);
    if (a[15:14] == WIN_ROM0 || a[15:14] == WIN_ROMX) return rom_img.exists(rom_index(a));
    if (a[15:13] == WIN_RAM && ram_on) return ram_img.exists(ram_index(a));
    return 1'b1;
  endfunction

  function automatic bus_reply_t cart_access(op_t op, logic [15:0] a, logic [7:0] d,
                                             logic [20:0] ofs);
    bus_reply_t r;
    r = '0;
    case (op)
      OP_READ: begin
        if (a[15:14] == WIN_ROM0 || a[15:14] == WIN_ROMX) r.rd = rom_img[rom_index(a)];
        else if (a[15:13] == WIN_RAM && ram_on) r.rd = ram_img[ram_index(a)];
      end
      OP_WRITE: begin
        case (a[15:13])
          WIN_RAM: begin
            if (ram_on) put_ram(ram_index(a), d);
          end
          REG_RAM_EN: ram_on = (d[3:0] == RAM_EN_KEY);
          REG_BANK_LO: begin
            bank_sel[BANK_LO_W-1:0] = (d[BANK_LO_W-1:0] == '0) ? BANK_LO_ONE
                                                                : d[BANK_LO_W-1:0];
          end
          REG_BANK_HI: bank_sel[BANK_W-1:BANK_LO_W] = d[BANK_HI_W-1:0];
          REG_MODE: begin
            if (d == MODE_ROM) ram_mode = 1'b0;
            else if (d == MODE_RAM) ram_mode = 1'b1;
            else r.bad = 1'b1;
          end
          default: ;
        endcase
      end
      OP_LOAD_ROM: put_rom(32'(ofs) % ROM_BYTES, d);
      default: put_ram(32'(ofs) % RAM_BYTES, d);
    endcase
    return r;
  endfunction

  function automatic logic [15:0] addr_in(logic [2:0] region);
    logic [12:0] o;
    o = 13'($urandom);
    return {region, o};
  endfunction

  function automatic logic [15:0] unmapped_addr();
    logic [15:0] a;
    a = 16'($urandom);
    a[15] = 1'b1;
    if (a[15:13] == WIN_RAM) a[14] = 1'b1;
    return a;
  endfunction

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    $display("ERROR %0t: %s is %0h, predicted %0h", $time, field, got, want);
    errors++;
  endtask

  task automatic send(op_t op, logic [15:0] a, logic [7:0] d, logic [20:0] ofs);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid   <= 1'b1;
    operation    <= op;
    address      <= a;
    data         <= d;
    image_offset <= ofs;
    do @(posedge clk); while (item_stall);
    bus_replies.push_back(cart_access(op, a, d, ofs));
    items_sent++;
  endtask

  task automatic bus_read(logic [15:0] a);
    send(OP_READ, a, 8'($urandom), 21'($urandom));
  endtask

  task automatic bus_write(logic [15:0] a, logic [7:0] d);
    send(OP_WRITE, a, d, 21'($urandom));
  endtask

  task automatic load_rom(logic [20:0] ofs, logic [7:0] d);
    send(OP_LOAD_ROM, 16'($urandom), d, ofs);
  endtask

  task automatic load_ram(logic [20:0] ofs, logic [7:0] d);
    send(OP_LOAD_RAM, 16'($urandom), d, ofs);
  endtask

  task automatic select_rom_bank(logic [6:0] b);
    logic [7:0] lo;
    lo = (8'($urandom) & 8'hE0) | {3'b000, b[BANK_LO_W-1:0]};
    // low bits of zero must come back as bank one
    if (b[BANK_LO_W-1:0] == BANK_LO_ONE && $urandom_range(1)) lo[BANK_LO_W-1:0] = '0;
    bus_write(addr_in(REG_BANK_LO), lo);
    bus_write(addr_in(REG_BANK_HI),
              (8'($urandom) & 8'hFC) | {6'd0, b[BANK_W-1:BANK_LO_W]});
    bus_write(addr_in(REG_MODE),
              (b[BANK_W-1:BANK_LO_W] != '0 || $urandom_range(1)) ? MODE_ROM : MODE_RAM);
  endtask

  task automatic select_ram_bank(logic [1:0] rb);
    bus_write(addr_in(REG_BANK_HI), (8'($urandom) & 8'hFC) | {6'd0, rb});
    bus_write(addr_in(REG_MODE), (rb == '0 && $urandom_range(1)) ? MODE_ROM : MODE_RAM);
  endtask

  task automatic set_ram_enable(bit enable);
    logic [7:0] d;
    d = 8'($urandom);
    if (enable) d[3:0] = RAM_EN_KEY;
    else if (d[3:0] == RAM_EN_KEY) d[0] = ~d[0];
    bus_write(addr_in(REG_RAM_EN), d);
  endtask

  task automatic test_reset_defaults();
    load_rom(21'h000000, 8'h5A);
    load_rom(21'h003FFF, 8'hA5);
    load_rom(21'h004000, 8'hC3);
    bus_read(16'h0000);
    bus_read(16'h3FFF);
    bus_read(16'h4000);
    bus_read(16'hA000);
    bus_read(16'h8000);
    bus_read(16'hFFFF);
  endtask

  task automatic test_rom_bank_select();
    bus_write(16'h2000, 8'h00);
    bus_read(16'h4000);
    load_rom(21'h1FFFFF, 8'hFF);
    bus_write(16'h3FFF, 8'hFF);
    bus_write(16'h5FFF, 8'hFF);
    bus_read(16'h7FFF);
  endtask

  task automatic test_mode_and_ram();
    bus_write(16'h6000, 8'h02);
    bus_write(16'h7FFF, 8'hFF);
    load_rom(21'h07FFFF, 8'h81);
    // RAM banking masks the ROM bank down to its low bits
    bus_write(16'h6000, MODE_RAM);
    bus_read(16'h7FFF);
    bus_write(16'h0000, 8'hFA);
    load_ram(21'h1FFFFF, 8'h77);
    bus_read(16'hBFFF);
    bus_write(16'hA000, 8'h00);
    bus_read(16'hA000);
    bus_write(16'h1FFF, 8'h0B);
    bus_read(16'hBFFF);
    bus_write(16'hA001, 8'h12);
    bus_write(16'h6000, MODE_ROM);
  endtask

  task automatic test_random_traffic(int gap, int stall, int count);
    int          first;
    int          pick;
    logic [20:0] k;
    logic [20:0] ofs;
    logic [13:0] o;
    logic [6:0]  b;
    logic [1:0]  rb;
    logic [15:0] a;
    logic [7:0]  d;
    op_t         op;
    gap_pct   = gap;
    stall_pct = stall;
    first     = items_sent;
    while (items_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        // fill a ROM bank, often one already in use
        if (rom_keys.size() != 0 && $urandom_range(1))
          b = 7'(rom_keys[$urandom_range(rom_keys.size() - 1)] >> ROM_OFS_W);
        else
          b = 7'($urandom);
        repeat ($urandom_range(1, 6)) begin
          o = 14'($urandom);
          load_rom({b, o}, 8'($urandom));
        end
      end else if (pick < 45) begin
        if (rom_keys.size() != 0) begin
          k = rom_keys[$urandom_range(rom_keys.size() - 1)];
          b = k[20:ROM_OFS_W];
          if (b != '0 && b[BANK_LO_W-1:0] != '0) select_rom_bank(b);
          a = {((b == '0) ? WIN_ROM0 : WIN_ROMX), k[ROM_OFS_W-1:0]};
          repeat ($urandom_range(1, 4)) begin
            if (reachable(a)) bus_read(a);
            k = rom_keys[$urandom_range(rom_keys.size() - 1)];
            a = {((k[20:ROM_OFS_W] == '0) ? WIN_ROM0 : WIN_ROMX), k[ROM_OFS_W-1:0]};
          end
        end
      end else if (pick < 60) begin
        rb = 2'($urandom);
        repeat ($urandom_range(1, 6)) begin
          ofs = 21'($urandom);
          ofs[14:13] = rb;
          load_ram(ofs, 8'($urandom));
        end
      end else if (pick < 80) begin
        if (ram_keys.size() != 0 && $urandom_range(1)) begin
          k  = 21'(ram_keys[$urandom_range(ram_keys.size() - 1)]);
          rb = k[14:13];
          a  = {WIN_RAM, k[RAM_OFS_W-1:0]};
        end else begin
          rb = 2'($urandom);
          a  = addr_in(WIN_RAM);
        end
        set_ram_enable($urandom_range(9) != 0);
        select_ram_bank(rb);
        if (reachable(a)) bus_read(a);
        repeat ($urandom_range(1, 3)) begin
          a = addr_in(WIN_RAM);
          bus_write(a, 8'($urandom));
          if ($urandom_range(1)) bus_read(a);
        end
      end else if (pick < 88) begin
        d = 8'($urandom);
        if ($urandom_range(2) == 0) d = $urandom_range(1) ? MODE_RAM : MODE_ROM;
        bus_write(addr_in(REG_MODE), d);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          op = op_t'($urandom_range(3));
          a  = 16'($urandom);
          if (op == OP_READ && !reachable(a)) a = unmapped_addr();
          send(op, a, 8'($urandom), 21'($urandom));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (bus_replies.size() == 0) begin
        report_mismatch("read_data of unrequested transfer", read_data, 8'h00);
      end else begin
        oldest_reply = bus_replies.pop_front();
        if (read_data !== oldest_reply.rd)
          report_mismatch("read_data", read_data, oldest_reply.rd);
        if (bad_mode_write !== oldest_reply.bad)
          report_mismatch("bad_mode_write", 8'(bad_mode_write), 8'(oldest_reply.bad));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_rom_bank_select();
    test_mode_and_ram();
    test_random_traffic(31, 69, 410);
    test_random_traffic(69, 31, 410);
    test_random_traffic(0, 0, 410);
    @(negedge clk);
    item_valid <= 1'b0;
    while (bus_replies.size() != 0) @(posedge clk);
    // catch any stray result after the last one
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("mbc1_bank_controller: match");
    end else begin
      $display("mbc1_bank_controller: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("mbc1_bank_controller: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/mbc1_pkg.sv
design/mbc1_ctrl.sv
design/mbc1_store.sv
design/mbc1_out.sv
design/mbc1_bank_controller.sv
sim/tb_top.sv
